### hw/rtl/lse_pkg.sv
package lse_pkg;

  // Line geometry.
  localparam int LINE_PIXELS = 128;
  localparam int IDX_W       = $clog2(LINE_PIXELS);

  // Pixel pairs are compared for left indices WIN_FIRST..WIN_LAST.
  localparam int WIN_FIRST = 2;
  localparam int WIN_LAST  = 122;

  // Steering constants.
  localparam logic [6:0]        RISE_BASE = 7'd64;
  localparam logic [6:0]        CENTER    = 7'd63;
  localparam logic signed [7:0] BIAS_POS  = 8'sd30;
  localparam logic signed [7:0] BIAS_NEG  = 8'sd50;
  localparam logic [1:0]        COUNT_MAX = 2'd3;
  localparam logic [1:0]        COUNT_TWO = 2'd2;

  // Edge summary of the line seen so far.
  typedef struct packed {
    logic signed [6:0] rising;
    logic signed [6:0] falling;
    logic [1:0]        count;
    logic [IDX_W-1:0]  last;
  } line_state_t;

endpackage

### hw/rtl/line_scan_edge_steering_core.sv
// A pixel accepted into the input register is processed once the result
// register can take a result; processing a line's last pixel loads its result.
// Throughput: one pixel per cycle while the result side does not stall, set by
// the single input and result registers around the compare and steering logic.
// Reset (rst, synchronous, active high) empties both registers and clears
// the line state, so the next pixel is index 0 of a new line.
module line_scan_edge_steering_core
  import lse_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  logic [7:0]        pixel,
  input  logic              line_end,
  output logic              result_valid,
  input  logic              result_ready,
  output logic signed [7:0] steer,
  output logic              two_edges
);

  logic              hold_valid;
  logic [7:0]        hold_pixel;
  logic              hold_end;
  logic              proc_en;
  logic              done;
  line_state_t       upd;
  logic signed [7:0] steer_calc;
  logic              two_calc;

  // A held pixel is processed once the result register can take a result.
  assign proc_en    = hold_valid && (!result_valid || result_ready);
  assign item_ready = !hold_valid || proc_en;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item_ready) begin
      hold_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      hold_pixel <= pixel;
      hold_end   <= line_end;
    end
  end

  lse_edge_track u_track (
    .clk      (clk),
    .rst      (rst),
    .en       (proc_en),
    .pixel    (hold_pixel),
    .line_end (hold_end),
    .upd      (upd),
    .done     (done)
  );

  lse_steer_calc u_calc (
    .st        (upd),
    .steer     (steer_calc),
    .two_edges (two_calc)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (proc_en && done) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_en && done) begin
      steer     <= steer_calc;
      two_edges <= two_calc;
    end
  end

endmodule

### hw/rtl/lse_edge_track.sv
module lse_edge_track
  import lse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic [7:0]  pixel,
  input  logic        line_end,
  output line_state_t upd,
  output logic        done
);

  logic [IDX_W-1:0] pixel_index;
  logic [7:0]       previous_pixel;
  line_state_t      line_state;
  logic [IDX_W-1:0] left;
  logic             in_win;

  // Compare the pixel with its left neighbour inside the window.
  always_comb begin
    left   = pixel_index - IDX_W'(1);
    in_win = (pixel_index >= IDX_W'(WIN_FIRST + 1)) &&
             (pixel_index <= IDX_W'(WIN_LAST + 1));
    upd    = line_state;
    if (in_win) begin
      if (previous_pixel < pixel) begin
        upd.rising = RISE_BASE - left;
      end
      if (previous_pixel > pixel) begin
        upd.falling = left - CENTER;
      end
      if (previous_pixel != pixel) begin
        if (line_state.count != COUNT_MAX) begin
          upd.count = line_state.count + 2'd1;
        end
        upd.last = left;
      end
    end
    done = line_end || (pixel_index == IDX_W'(LINE_PIXELS - 1));
  end

  // Line state: cleared at reset and after the line's last pixel.
  always_ff @(posedge clk) begin
    if (rst || (en && done)) begin
      pixel_index    <= '0;
      previous_pixel <= '0;
      line_state     <= '0;
    end else if (en) begin
      pixel_index    <= pixel_index + IDX_W'(1);
      previous_pixel <= pixel;
      line_state     <= upd;
    end
  end

endmodule

### hw/rtl/lse_steer_calc.sv
module lse_steer_calc
  import lse_pkg::*;
(
  input  line_state_t       st,
  output logic signed [7:0] steer,
  output logic              two_edges
);

  logic signed [7:0] pair_diff;
  logic signed [7:0] centre_ofs;

  // When two_edges is set, steer is the offset difference; otherwise steer from the last edge.
  always_comb begin
    two_edges  = (st.count == COUNT_TWO);
    pair_diff  = {st.rising[6], st.rising} - {st.falling[6], st.falling};
    centre_ofs = $signed({1'b0, CENTER}) - $signed({1'b0, st.last});
    if (two_edges) begin
      steer = pair_diff;
    end else if (centre_ofs > 8'sd0) begin
      steer = centre_ofs + BIAS_POS;
    end else if (centre_ofs < 8'sd0) begin
      steer = centre_ofs - BIAS_NEG;
    end else begin
      steer = 8'sd0;
    end
  end

endmodule

### hw/rtl/lse_checker.sv
module lse_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic [7:0]        pixel,
  input logic              line_end,
  input logic              result_valid,
  input logic              result_ready,
  input logic signed [7:0] steer,
  input logic              two_edges
);

  // A stalled pixel transaction holds its payload.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_ready |=> item_valid && $stable(pixel) && $stable(line_end))
    else $error("pixel changed while stalled");

  // A stalled result transaction holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(steer) && $stable(two_edges))
    else $error("result changed while stalled");

  // The result register is empty in the cycle after reset.
  a_reset: assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid straight after reset");

  // Results with two_edges set stay within the offset difference range.
  a_two_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && two_edges |-> steer >= -8'sd117 && steer <= 8'sd123)
    else $error("two-edge steer out of range");

  // Single-position results carry their bias or are zero.
  a_bias: assert property (@(posedge clk) disable iff (rst)
    result_valid && !two_edges |->
      steer == 8'sd0 || (steer >= 8'sd31 && steer <= 8'sd93) ||
      (steer <= -8'sd51 && steer >= -8'sd109))
    else $error("biased steer out of range");

endmodule

bind line_scan_edge_steering_core lse_checker u_lse_checker (.*);

### tb/sv/line_scan_edge_steering_core_test.sv
`timescale 1ns / 1ps

module line_scan_edge_steering_core_test;
  import lse_pkg::*;

  localparam int QUIET_TAIL     = 250;
  localparam int MISMATCH_SHOWN = 10;
  localparam int RANDOM_PIXELS  = 1800;
  localparam int RANDOM_LINES   = 13;

  typedef struct {
    logic [7:0] level;
    logic       last;
    bit         drain_first;
  } pixel_item_t;

  typedef struct {
    logic signed [7:0] steer;
    logic              two;
  } steering_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_ready;
  logic [7:0]        pixel = 8'd0;
  logic              line_end = 1'b0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  logic signed [7:0] steer;
  logic              two_edges;

  pixel_item_t pixel_queue[$];
  steering_t   expected_steering[$];
  int          mismatches = 0;
  int          send_gap = 0;
  int          take_gap = 0;

  // Line state of the predictor.
  logic [6:0]        line_pos;
  logic [7:0]        prev_level;
  logic signed [6:0] rise_ofs;
  logic signed [6:0] fall_ofs;
  logic [1:0]        edge_count;
  logic [6:0]        last_edge;

  line_scan_edge_steering_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .pixel        (pixel),
    .line_end     (line_end),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .steer        (steer),
    .two_edges    (two_edges)
  );

  always #2 clk = ~clk;

  task automatic restart_line();
    line_pos   = '0;
    prev_level = '0;
    rise_ofs   = '0;
    fall_ofs   = '0;
    edge_count = '0;
    last_edge  = '0;
  endtask

  // Updates the edge summary with one accepted pixel and, at the end of a
  // line, queues the steering value that the line should produce.
  task automatic follow_pixel(input logic [7:0] level, input logic last);
    logic [6:0] left;
    int         offset;
    steering_t  result;
    left = line_pos - 7'd1;
    if (line_pos >= WIN_FIRST + 1 && line_pos <= WIN_LAST + 1) begin
      if (prev_level < level) rise_ofs = 7'(int'(RISE_BASE) - int'(left));
      if (prev_level > level) fall_ofs = 7'(int'(left) - int'(CENTER));
      if (prev_level != level) begin
        if (edge_count != COUNT_MAX) edge_count = edge_count + 2'd1;
        last_edge = left;
      end
    end
    prev_level = level;
    if (!last && line_pos != 7'(LINE_PIXELS - 1)) begin
      line_pos = line_pos + 7'd1;
    end else begin
      result.two = (edge_count == COUNT_TWO);
      if (result.two) begin
        offset = int'(rise_ofs) - int'(fall_ofs);
      end else begin
        offset = int'(CENTER) - int'(last_edge);
        if (offset < 0) offset = offset - int'(BIAS_NEG);
        else if (offset > 0) offset = offset + int'(BIAS_POS);
      end
      result.steer = 8'(offset);
      expected_steering.push_back(result);
      restart_line();
    end
  endtask

  task automatic add_pixel(input logic [7:0] level, input logic last, input bit drain_first);
    pixel_item_t item;
    item.level       = level;
    item.last        = last;
    item.drain_first = drain_first;
    pixel_queue.push_back(item);
  endtask

  // Builds one line: mostly a flat background with a few steps placed at
  // random, sometimes pure noise, sometimes a last step right at the centre.
  task automatic add_random_line(input bit drain_first);
    bit         step_after[128];
    logic [7:0] level;
    int         len, hi, k, p, mode, pick;
    bit         ends_marked, noise;
    pick = $urandom_range(99);
    if (pick < 25) begin
      len = LINE_PIXELS;
      ends_marked = 1'b1;
    end else if (pick < 35) begin
      len = LINE_PIXELS;
      ends_marked = 1'b0;
    end else begin
      len = ($urandom_range(7) == 0) ? $urandom_range(61, 127) : $urandom_range(1, 60);
      ends_marked = 1'b1;
    end
    hi = (len >= 2) ? len - 2 : 0;
    foreach (step_after[i]) step_after[i] = 1'b0;
    mode  = $urandom_range(9);
    noise = (mode == 0);
    if (mode == 1) begin
      // When the line reaches it, the last counted step sits at the centre, so the offset comes out as zero.
      k = $urandom_range(0, 3);
      for (int j = 0; j < k; j++) step_after[$urandom_range(0, 62)] = 1'b1;
      step_after[63] = 1'b1;
      if ($urandom_range(1) == 1) step_after[$urandom_range(123, 126)] = 1'b1;
    end else if (!noise) begin
      pick = $urandom_range(6);
      case (pick)
        0:       k = 0;
        1:       k = 1;
        5:       k = 3;
        6:       k = $urandom_range(4, 10);
        default: k = 2;
      endcase
      for (int j = 0; j < k; j++) begin
        if (hi >= WIN_FIRST && $urandom_range(3) != 0)
          p = $urandom_range(WIN_FIRST, (hi < WIN_LAST) ? hi : WIN_LAST);
        else
          p = $urandom_range(0, hi);
        step_after[p] = 1'b1;
      end
    end
    level = 8'($urandom);
    for (int i = 0; i < len; i++) begin
      if (noise) level = 8'($urandom);
      else if (i > 0 && step_after[i - 1]) level = level ^ 8'($urandom_range(1, 255));
      add_pixel(level, ends_marked && (i == len - 1), drain_first && (i == 0));
    end
  endtask

  // Driver: presents pixel transactions from the queue and feeds every
  // accepted one to the predictor.
  always @(posedge clk) begin
    pixel_item_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
      send_gap = 0;
      restart_line();
    end else begin
      if (item_valid && item_ready) follow_pixel(pixel, line_end);
      if (!item_valid || item_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          item_valid <= 1'b0;
        end else if (pixel_queue.size() == 0 ||
                     (pixel_queue[0].drain_first && expected_steering.size() != 0)) begin
          item_valid <= 1'b0;
        end else begin
          nxt = pixel_queue.pop_front();
          item_valid <= 1'b1;
          pixel      <= nxt.level;
          line_end   <= nxt.last;
          if (pixel_queue.size() > QUIET_TAIL && $urandom_range(9) == 0)
            send_gap = $urandom_range(1, 13);
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest prediction
  // and stalls the result side in random bursts.
  always @(posedge clk) begin
    steering_t want;
    if (rst) begin
      result_ready <= 1'b0;
      take_gap = 0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_steering.size() == 0) begin
          mismatches++;
          if (mismatches <= MISMATCH_SHOWN)
            $display("%0t: unexpected result steer=%0d two_edges=%0b",
                     $realtime, steer, two_edges);
        end else begin
          want = expected_steering.pop_front();
          if (steer !== want.steer || two_edges !== want.two) begin
            mismatches++;
            if (mismatches <= MISMATCH_SHOWN)
              $display("%0t: steer expected %0d got %0d, two_edges expected %0b got %0b",
                       $realtime, want.steer, steer, want.two, two_edges);
          end
        end
      end
      if (take_gap != 0) begin
        take_gap--;
        result_ready <= 1'b0;
      end else if (pixel_queue.size() > QUIET_TAIL && $urandom_range(11) == 0) begin
        take_gap = $urandom_range(0, 12);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Stimulus, reset and the end of the run.
  initial begin
    int lines;
    // A single pixel that also ends its line: no transitions at all.
    add_pixel(8'd255, 1'b1, 1'b0);
    // One rise at the first compared pair.
    add_pixel(8'd0, 1'b0, 1'b0);
    add_pixel(8'd0, 1'b0, 1'b0);
    add_pixel(8'd0, 1'b0, 1'b0);
    add_pixel(8'd255, 1'b1, 1'b0);
    // A fall then a rise: exactly two transitions.
    add_pixel(8'd255, 1'b0, 1'b0);
    add_pixel(8'd255, 1'b0, 1'b0);
    add_pixel(8'd255, 1'b0, 1'b0);
    add_pixel(8'd0, 1'b0, 1'b0);
    add_pixel(8'd255, 1'b0, 1'b0);
    add_pixel(8'd255, 1'b1, 1'b0);
    // A rise then a fall, with a step between pixels 0 and 1 that is ignored.
    add_pixel(8'd255, 1'b0, 1'b0);
    add_pixel(8'd0, 1'b0, 1'b0);
    add_pixel(8'd0, 1'b0, 1'b0);
    add_pixel(8'd0, 1'b0, 1'b0);
    add_pixel(8'd255, 1'b0, 1'b0);
    add_pixel(8'd0, 1'b0, 1'b0);
    add_pixel(8'd0, 1'b1, 1'b0);
    // Three transitions, so the count saturates.
    add_pixel(8'd0, 1'b0, 1'b0);
    add_pixel(8'd0, 1'b0, 1'b0);
    add_pixel(8'd0, 1'b0, 1'b0);
    add_pixel(8'd255, 1'b0, 1'b0);
    add_pixel(8'd0, 1'b0, 1'b0);
    add_pixel(8'd255, 1'b1, 1'b0);
    lines = 0;
    while (pixel_queue.size() < RANDOM_PIXELS || lines < RANDOM_LINES) begin
      add_random_line(lines % 12 == 0);
      lines++;
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pixel_queue.size() != 0 || item_valid || expected_steering.size() != 0);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
